// ----- src/btrc_pkg.sv -----
// Shared types and constants for the breakpoint table run control block.
package btrc_pkg;

   localparam int TABLE_DEPTH = 2048;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int ADDR_W      = 16;
   localparam int RUN_W       = 32;
   localparam int ENTRY_W     = 12;

   localparam logic signed [RUN_W-1:0] RUN_FREE = -1;

   typedef enum logic [1:0] {
      OP_CHECK = 2'd0,
      OP_ADD   = 2'd1,
      OP_DEL   = 2'd2,
      OP_RUN   = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_PRESENT = 2'd1,
      ST_ABSENT  = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_MOVE,
      S_FINISH
   } state_type;

   typedef struct packed {
      opcode_type               opcode;
      logic [ADDR_W-1:0]        address;
      logic signed [RUN_W-1:0]  run_count;
   } req_type;

   typedef struct packed {
      logic                     break_hit;
      logic                     halt;
      status_type               status;
      logic [ENTRY_W-1:0]       entry_count;
   } rsp_type;

endpackage

// ----- src/breakpoint_table_run_control.sv -----
// Breakpoint table with run control: address table in one synchronous RAM.
// Check, add and delete walk the stored entries one per cycle until a hit or
// the end of the table; a delete of any entry but the last moves the last
// entry into the hole. Set-run loads the run counter. One item is in work at a
// time; the next is taken while the previous result still waits in the output
// register. Reset clears the entry count, run counter and handshake state.
module breakpoint_table_run_control (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  btrc_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output btrc_pkg::rsp_type  rsp_data
);
   import btrc_pkg::*;

   logic [ADDR_W-1:0] mem [TABLE_DEPTH];
   logic [ADDR_W-1:0] mem_q_ff;
   logic              mem_we;
   logic [IDX_W-1:0]  mem_wa;
   logic [ADDR_W-1:0] mem_wd;
   logic              mem_re;
   logic [IDX_W-1:0]  mem_ra;

   state_type               state_ff, state_in;
   req_type                 req_ff, req_in;
   logic [CNT_W-1:0]        scan_idx_ff, scan_idx_in;
   logic                    cmp_valid_ff, cmp_valid_in;
   logic [IDX_W-1:0]        cmp_idx_ff, cmp_idx_in;
   logic [IDX_W-1:0]        slot_ff, slot_in;
   logic [CNT_W-1:0]        total_ff, total_in;
   logic signed [RUN_W-1:0] run_ff, run_in;
   rsp_type                 res_ff, res_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;

   logic                    hit_now;
   logic                    miss_now;
   logic [IDX_W-1:0]        last_idx;
   logic signed [RUN_W-1:0] run_base;

   assign hit_now   = cmp_valid_ff && (mem_q_ff == req_ff.address);
   assign miss_now  = !hit_now && (scan_idx_ff == total_ff);
   assign last_idx  = IDX_W'(total_ff - CNT_W'(1));
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      scan_idx_in  = scan_idx_ff;
      cmp_valid_in = 1'b0;
      cmp_idx_in   = cmp_idx_ff;
      slot_in      = slot_ff;
      total_in     = total_ff;
      run_in       = run_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_wa       = cmp_idx_ff;
      mem_wd       = req_ff.address;
      mem_re       = 1'b0;
      mem_ra       = scan_idx_ff[IDX_W-1:0];
      run_base     = hit_now ? '0 : run_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in             = req_data;
               scan_idx_in        = '0;
               res_in.break_hit   = 1'b0;
               res_in.halt        = 1'b0;
               res_in.status      = ST_OK;
               res_in.entry_count = '0;
               if (req_data.opcode == OP_RUN) begin
                  run_in   = req_data.run_count;
                  state_in = S_FINISH;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (hit_now || miss_now) begin
               state_in = S_FINISH;
               case (req_ff.opcode)
                  OP_CHECK: begin
                     res_in.break_hit = hit_now;
                     if (run_base == RUN_FREE) begin
                        run_in = run_base;
                     end else if (run_base > 0) begin
                        run_in = run_base - RUN_W'(1);
                     end else begin
                        run_in      = run_base;
                        res_in.halt = 1'b1;
                     end
                  end
                  OP_ADD: begin
                     if (hit_now) begin
                        res_in.status = ST_PRESENT;
                     end else if (total_ff == CNT_W'(TABLE_DEPTH)) begin
                        res_in.status = ST_FULL;
                     end else begin
                        mem_we   = 1'b1;
                        mem_wa   = total_ff[IDX_W-1:0];
                        total_in = total_ff + CNT_W'(1);
                     end
                  end
                  OP_DEL: begin
                     if (!hit_now) begin
                        res_in.status = ST_ABSENT;
                     end else if (cmp_idx_ff == last_idx) begin
                        total_in = total_ff - CNT_W'(1);
                     end else begin
                        // fetch the last entry to fill the hole
                        mem_re   = 1'b1;
                        mem_ra   = last_idx;
                        slot_in  = cmp_idx_ff;
                        state_in = S_MOVE;
                     end
                  end
                  default: begin
                     state_in = S_FINISH;
                  end
               endcase
            end else if (scan_idx_ff != total_ff) begin
               mem_re       = 1'b1;
               cmp_valid_in = 1'b1;
               cmp_idx_in   = scan_idx_ff[IDX_W-1:0];
               scan_idx_in  = scan_idx_ff + CNT_W'(1);
            end
         end
         S_MOVE: begin
            mem_we   = 1'b1;
            mem_wa   = slot_ff;
            mem_wd   = mem_q_ff;
            total_in = total_ff - CNT_W'(1);
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in              = res_ff;
               rsp_data_in.entry_count  = ENTRY_W'(total_ff);
               state_in                 = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cmp_valid_ff <= 1'b0;
         total_ff     <= '0;
         run_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cmp_valid_ff <= cmp_valid_in;
         total_ff     <= total_in;
         run_ff       <= run_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      scan_idx_ff <= scan_idx_in;
      cmp_idx_ff  <= cmp_idx_in;
      slot_ff     <= slot_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         mem_q_ff <= mem[mem_ra];
      end
   end

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   a_total_step: assert property (@(posedge clock) disable iff (reset)
      (total_ff != $past(total_ff)) |->
         (total_ff == $past(total_ff) + CNT_W'(1) || total_ff == $past(total_ff) - CNT_W'(1)))
      else $error("entry count moved by more than one");

   a_move_after_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MOVE) |-> ($past(state_ff) == S_SCAN))
      else $error("entry move without a finished scan");

   a_write_state: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == S_SCAN || state_ff == S_MOVE))
      else $error("table write outside scan or move");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_FINISH))
      else $error("result loaded outside finish");

endmodule

// ----- dv/breakpoint_table_run_control_tb.sv -----
// Self-checking testbench for the breakpoint table run control block.
`timescale 1ns / 1ps

module breakpoint_table_run_control_tb;
   import btrc_pkg::*;

   localparam int MAX_WAIT      = 14;
   localparam int HOLD_CYCLES   = 300;
   localparam int STALL_LIMIT   = 4 * (TABLE_DEPTH + 8 + 2 * MAX_WAIT) + HOLD_CYCLES;
   localparam int DRAIN_CYCLES  = 64;
   localparam int RANDOM_ITEMS  = 266;
   localparam int POOL_SIZE     = 32;
   localparam logic [ADDR_W-1:0] FILL_STRIDE = 16'd40503;

   // Predicts each response from the requests taken so far and holds the
   // expected responses in order.
   class breakpoint_scoreboard;
      logic [ADDR_W-1:0]       bp_table[TABLE_DEPTH];
      int                      stored;
      logic signed [RUN_W-1:0] run_left;
      rsp_type                 expected_q[$];
      int mismatches, requests, responses;
      int hits, halts, full_rejects, dup_rejects, miss_deletes, peak;

      function new();
         stored = 0;
         run_left = '0;
         mismatches = 0;
         requests = 0;
         responses = 0;
         hits = 0;
         halts = 0;
         full_rejects = 0;
         dup_rejects = 0;
         miss_deletes = 0;
         peak = 0;
      endfunction

      function int slot_of(logic [ADDR_W-1:0] addr);
         for (int i = 0; i < stored; i++)
            if (bp_table[i] == addr) return i;
         return -1;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void note_request(req_type r);
         rsp_type e;
         int      slot;
         e = '0;
         e.status = ST_OK;
         slot = slot_of(r.address);
         case (r.opcode)
            OP_CHECK: begin
               if (slot >= 0) begin
                  e.break_hit = 1'b1;
                  run_left = '0;
                  hits++;
               end
               if (run_left == RUN_FREE) begin
                  e.halt = 1'b0;
               end else if (run_left > 0) begin
                  run_left = run_left - 1;
                  e.halt = 1'b0;
               end else begin
                  e.halt = 1'b1;
                  halts++;
               end
            end
            OP_ADD: begin
               if (slot >= 0) begin
                  e.status = ST_PRESENT;
                  dup_rejects++;
               end else if (stored >= TABLE_DEPTH) begin
                  e.status = ST_FULL;
                  full_rejects++;
               end else begin
                  bp_table[stored] = r.address;
                  stored++;
               end
            end
            OP_DEL: begin
               if (slot < 0) begin
                  e.status = ST_ABSENT;
                  miss_deletes++;
               end else begin
                  // last entry fills the hole
                  bp_table[slot] = bp_table[stored - 1];
                  stored--;
               end
            end
            default: run_left = r.run_count;
         endcase
         if (stored > peak) peak = stored;
         e.entry_count = stored[ENTRY_W-1:0];
         expected_q.push_back(e);
         requests++;
      endfunction

      function void check_result(rsp_type got);
         rsp_type e;
         responses++;
         if (expected_q.size() == 0) begin
            if (mismatches < 10)
               $display("Response %0d arrived with no request outstanding", responses);
            mismatches++;
            return;
         end
         e = expected_q.pop_front();
         if (got.break_hit !== e.break_hit || got.halt !== e.halt ||
             got.status !== e.status || got.entry_count !== e.entry_count) begin
            if (mismatches < 10)
               $display({"Mismatch on response %0d: expected hit=%0b halt=%0b status=%0d ",
                         "count=%0d, got hit=%0b halt=%0b status=%0d count=%0d"},
                        responses, e.break_hit, e.halt, e.status, e.entry_count,
                        got.break_hit, got.halt, got.status, got.entry_count);
            mismatches++;
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   breakpoint_scoreboard sb;
   logic [ADDR_W-1:0]    addr_pool[POOL_SIZE];
   bit                   steady_flow = 1'b0;
   bit                   hold_request = 1'b0;

   breakpoint_table_run_control dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int pick_wait();
      if (steady_flow) return 0;
      return $urandom_range(0, MAX_WAIT);
   endfunction

   function automatic logic [ADDR_W-1:0] random_addr();
      return ADDR_W'($urandom_range(0, 65535));
   endfunction

   // Offer one request and hold it until the transfer happens.
   task automatic send_request(input req_type r);
      int gap;
      gap = pick_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note_request(r);
   endtask

   task automatic send_op(input opcode_type op, input logic [ADDR_W-1:0] addr,
                          input logic signed [RUN_W-1:0] count);
      req_type r;
      r.opcode = op;
      r.address = addr;
      r.run_count = count;
      send_request(r);
   endtask

   function automatic req_type random_request();
      req_type r;
      int      pick;
      r.opcode = OP_CHECK;
      r.run_count = $urandom;
      r.address = random_addr();
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         if (sb.stored > 0 && $urandom_range(0, 2) == 0)
            r.address = sb.bp_table[$urandom_range(0, sb.stored - 1)];
         else if ($urandom_range(0, 1) == 0)
            r.address = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
      end else if (pick < 65) begin
         r.opcode = OP_ADD;
         r.address = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
      end else if (pick < 82) begin
         r.opcode = OP_DEL;
         if (sb.stored > 0 && $urandom_range(0, 1) == 0)
            r.address = sb.bp_table[$urandom_range(0, sb.stored - 1)];
         else
            r.address = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
      end else begin
         r.opcode = OP_RUN;
         case ($urandom_range(0, 6))
            0: r.run_count = RUN_FREE;
            1: r.run_count = '0;
            2, 3: r.run_count = $urandom_range(1, 6);
            4: r.run_count = 32'sh7FFF_FFFF;
            5: r.run_count = ($urandom_range(0, 1) == 0) ? 32'sh8000_0000 : -32'sd2;
            default: ;
         endcase
      end
      return r;
   endfunction

   // Response side: random stall before each transfer, one long hold-off on request.
   initial begin : response_sink
      int hold;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            hold = HOLD_CYCLES;
         end else begin
            hold = pick_wait();
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         sb.check_result(rsp_data);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall))
            quiet = 0;
         else
            quiet++;
      end
      $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("Some tests failed");
      $finish;
   end

   initial begin : stimulus
      logic [ADDR_W-1:0] fill_addr;
      logic [ADDR_W-1:0] victim;
      sb = new;
      addr_pool[0] = 16'h0000;
      addr_pool[1] = 16'hFFFF;
      addr_pool[2] = 16'h8000;
      addr_pool[3] = 16'h0001;
      for (int i = 4; i < POOL_SIZE; i++) addr_pool[i] = random_addr();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table, free run, duplicates, counted run, hits, deletes
      send_op(OP_CHECK, 16'h0040, $urandom);
      send_op(OP_DEL, 16'hFFFF, $urandom);
      send_op(OP_RUN, random_addr(), RUN_FREE);
      send_op(OP_CHECK, 16'h0000, $urandom);
      send_op(OP_ADD, 16'h0000, $urandom);
      send_op(OP_ADD, 16'hFFFF, $urandom);
      send_op(OP_ADD, 16'h1234, $urandom);
      send_op(OP_ADD, 16'hFFFF, $urandom);
      send_op(OP_RUN, random_addr(), 32'sd2);
      repeat (3) send_op(OP_CHECK, 16'h5555, $urandom);
      send_op(OP_RUN, random_addr(), 32'sh7FFF_FFFF);
      send_op(OP_CHECK, 16'h1234, $urandom);
      send_op(OP_RUN, random_addr(), RUN_FREE);
      send_op(OP_CHECK, 16'hFFFF, $urandom);
      send_op(OP_RUN, random_addr(), 32'sh8000_0000);
      send_op(OP_CHECK, 16'h5555, $urandom);
      send_op(OP_RUN, random_addr(), -32'sd2);
      send_op(OP_CHECK, 16'h5555, $urandom);
      send_op(OP_DEL, 16'h0000, $urandom);
      send_op(OP_DEL, 16'hFFFF, $urandom);
      send_op(OP_DEL, 16'h1234, $urandom);
      send_op(OP_DEL, 16'h1234, $urandom);

      // random traffic over a small address pool keeps scans short
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 30 == 0) steady_flow = ($urandom_range(0, 3) == 0);
         if (i >= 120 && i < 140) steady_flow = 1'b1;
         if (i == 120) hold_request = 1'b1;
         send_request(random_request());
      end
      steady_flow = 1'b0;

      // fill the table with distinct addresses, then work it while full
      fill_addr = random_addr();
      while (sb.stored < TABLE_DEPTH) begin
         if (sb.slot_of(fill_addr) < 0) send_op(OP_ADD, fill_addr, $urandom);
         fill_addr = fill_addr + FILL_STRIDE;
      end
      while (sb.slot_of(fill_addr) >= 0) fill_addr = fill_addr + FILL_STRIDE;
      send_op(OP_ADD, fill_addr, $urandom);
      send_op(OP_ADD, sb.bp_table[0], $urandom);
      send_op(OP_RUN, random_addr(), 32'sd5);
      send_op(OP_CHECK, fill_addr, $urandom);
      send_op(OP_CHECK, sb.bp_table[TABLE_DEPTH - 1], $urandom);
      send_op(OP_DEL, sb.bp_table[TABLE_DEPTH - 1], $urandom);
      send_op(OP_ADD, fill_addr, $urandom);
      victim = sb.bp_table[0];
      send_op(OP_DEL, victim, $urandom);
      send_op(OP_DEL, victim, $urandom);
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d requests, %0d responses; table peaked at %0d of %0d entries",
               sb.requests, sb.responses, sb.peak, TABLE_DEPTH);
      $display("Break hits %0d, halts %0d, full %0d, duplicate adds %0d, missed deletes %0d",
               sb.hits, sb.halts, sb.full_rejects, sb.dup_rejects, sb.miss_deletes);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Mismatches: %0d", sb.mismatches);
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
